@@ sv/sfh_pkg.sv @@
// Shared types, constants and mixing functions for the string hash block.
// Depends on nothing; used by sfh_front, sfh_queue, sfh_back and string_hash_bucket.
package sfh_pkg;

   localparam int unsigned HASH_W      = 32;
   localparam int unsigned CHUNK_W     = 32;
   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned BUCKET_W    = 10;
   localparam int unsigned QUEUE_DEPTH = 2;

   // Byte counts in a chunk.
   localparam logic [COUNT_W-1:0] BYTES_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] BYTES_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] BYTES_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] BYTES_FULL  = 3'd4;

   // A finished pre-avalanche hash handed from the front to the queue.
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } push_type;

   function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
      return {{(HASH_W-8){b[7]}}, b};
   endfunction

   function automatic logic [HASH_W-1:0] mix_full(input logic [HASH_W-1:0] h_i,
                                                  input logic [CHUNK_W-1:0] w);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] t;
      h = h_i + {16'd0, w[15:0]};
      t = {5'd0, w[31:16], 11'd0} ^ h;
      h = {h[15:0], 16'd0} ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   function automatic logic [HASH_W-1:0] mix_tail(input logic [HASH_W-1:0] h_i,
                                                  input logic [CHUNK_W-1:0] w,
                                                  input logic [1:0] n);
      logic [HASH_W-1:0] h;
      h = h_i;
      unique case (n)
         2'd3: begin
            h = h + {16'd0, w[15:0]};
            h = h ^ (h << 16);
            h = h ^ (sext8(w[23:16]) << 18);
            h = h + (h >> 11);
         end
         2'd2: begin
            h = h + {16'd0, w[15:0]};
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         2'd1: begin
            h = h + sext8(w[7:0]);
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: begin
            h = h_i;
         end
      endcase
      return h;
   endfunction

   function automatic logic [HASH_W-1:0] avalanche(input logic [HASH_W-1:0] h_i);
      logic [HASH_W-1:0] h;
      h = h_i ^ (h_i << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

endpackage

@@ sv/sfh_front.sv @@
// Front end: accepts chunks, keeps the running hash and applies the per-chunk mixing.
// Depends on sfh_pkg; a finished string leaves as a push_type word for the queue.
module sfh_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [sfh_pkg::CHUNK_W-1:0]   chunk_bytes,
   input  logic [sfh_pkg::COUNT_W-1:0]   valid_bytes,
   input  logic                          first_chunk,
   input  logic                          last_chunk,
   input  logic [sfh_pkg::HASH_W-1:0]    total_length,
   output sfh_pkg::push_type             push
);

   logic [sfh_pkg::HASH_W-1:0] running_ff;
   logic [sfh_pkg::HASH_W-1:0] running_in;
   logic [sfh_pkg::HASH_W-1:0] seed;
   logic [sfh_pkg::HASH_W-1:0] full_mix;
   logic [sfh_pkg::HASH_W-1:0] tail_mix;

   assign seed     = first_chunk ? total_length : running_ff;
   assign full_mix = sfh_pkg::mix_full(seed, chunk_bytes);
   assign tail_mix = sfh_pkg::mix_tail(seed, chunk_bytes, valid_bytes[1:0]);

   always_comb begin
      running_in = running_ff;
      push.valid = 1'b0;
      push.hash  = full_mix;
      if (accept) begin
         if (!last_chunk) begin
            running_in = full_mix;
         end else begin
            // Counts of four and above all take the full step.
            push.valid = 1'b1;
            push.hash  = (valid_bytes >= sfh_pkg::BYTES_FULL) ? full_mix : tail_mix;
            running_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

@@ sv/sfh_queue.sv @@
// Short queue of pre-avalanche hashes between the front and the back end.
// Depends on sfh_pkg for the word type and depth.
module sfh_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  sfh_pkg::push_type           push,
   input  logic                        pop,
   output logic                        full,
   output logic                        not_empty,
   output logic [sfh_pkg::HASH_W-1:0]  head
);

   localparam int unsigned DEPTH = sfh_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [sfh_pkg::HASH_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];
   assign do_push   = push.valid;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/sfh_back.sv @@
// Back end: takes a hash from the queue, applies the avalanche and holds the result word.
// Depends on sfh_pkg for widths and the avalanche function.
module sfh_back #(
   parameter int unsigned BUCKET_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          have_word,
   input  logic [sfh_pkg::HASH_W-1:0]    head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfh_pkg::HASH_W-1:0]    rsp_full_hash,
   output logic [sfh_pkg::BUCKET_W-1:0]  rsp_bucket_index
);

   localparam logic [sfh_pkg::HASH_W-1:0] BUCKET_MASK =
      sfh_pkg::HASH_W'((64'd1 << BUCKET_BITS) - 64'd1);

   logic                         valid_ff, valid_in;
   logic [sfh_pkg::HASH_W-1:0]   hash_ff;
   logic [sfh_pkg::HASH_W-1:0]   mixed;

   assign mixed    = sfh_pkg::avalanche(head);
   // The output register takes a new word whenever it is empty or being drained.
   assign pop      = have_word && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (pop) begin
         hash_ff <= mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_full_hash    = hash_ff;
   assign rsp_bucket_index = sfh_pkg::BUCKET_W'(hash_ff & BUCKET_MASK);

endmodule

@@ sv/string_hash_bucket.sv @@
// Top level of the streaming 32-bit SuperFastHash block with bucket output.
// Depends on sfh_pkg, sfh_front, sfh_queue and sfh_back.
//
// Strings arrive as little-endian four-byte chunks, one chunk per cycle while the
// queue is not full; the first chunk seeds the hash with the total length and the
// last chunk (0 to 4 bytes) produces one result word carrying the hash and its low
// BUCKET_BITS bits as the bucket. A new chunk is taken in each of those cycles: the
// running-hash register in the front end closes the loop on its own. A finished
// string is written into a two-entry queue when its last chunk is taken; the back
// end then applies the avalanche into the output register, which presents the
// result word. The input stalls only while the queue is full.
module string_hash_bucket #(
   parameter int unsigned BUCKET_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sfh_pkg::CHUNK_W-1:0]   req_chunk_bytes,
   input  logic [sfh_pkg::COUNT_W-1:0]   req_valid_bytes,
   input  logic                          req_first_chunk,
   input  logic                          req_last_chunk,
   input  logic [sfh_pkg::HASH_W-1:0]    req_total_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfh_pkg::HASH_W-1:0]    rsp_full_hash,
   output logic [sfh_pkg::BUCKET_W-1:0]  rsp_bucket_index
);

   sfh_pkg::push_type            push;
   logic                         accept;
   logic                         queue_full;
   logic                         queue_not_empty;
   logic                         pop;
   logic [sfh_pkg::HASH_W-1:0]   head;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   sfh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .chunk_bytes  (req_chunk_bytes),
      .valid_bytes  (req_valid_bytes),
      .first_chunk  (req_first_chunk),
      .last_chunk   (req_last_chunk),
      .total_length (req_total_length),
      .push         (push)
   );

   sfh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   sfh_back #(
      .BUCKET_BITS (BUCKET_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .have_word        (queue_not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_full_hash    (rsp_full_hash),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule
